// ----- sv/wvs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wvs_pkg: shared types and constants of the wind vector statistics block
// Widths, fixed-point constants and the CORDIC arc-tangent table.
// ----------------------------------------------------------------------------
package wvs_pkg;

   localparam int SPEED_WIDTH = 16;
   localparam int ANGLE_WIDTH = 16;
   localparam int COUNT_WIDTH = 16;
   localparam int SUM_WIDTH   = SPEED_WIDTH + COUNT_WIDTH + 2;
   localparam int GUARD_BITS  = 60 - SUM_WIDTH;
   localparam int STEPS       = 30;
   localparam int STEP_BITS   = 5;
   localparam int ROT_FRAC    = 16;
   localparam int WORK_WIDTH  = 64;

   localparam logic [29:0] GAIN_Q30 = 30'd652032874;

   typedef struct packed {
      logic [ANGLE_WIDTH-1:0] wind_direction;
      logic [SPEED_WIDTH-1:0] wind_speed;
   } item_type;

   function automatic logic [31:0] arc_angle(input logic [STEP_BITS-1:0] idx);
      logic [31:0] a;
      unique case (idx)
         5'd0:    a = 32'h20000000;
         5'd1:    a = 32'h12E4051E;
         5'd2:    a = 32'h09FB385B;
         5'd3:    a = 32'h051111D4;
         5'd4:    a = 32'h028B0D43;
         5'd5:    a = 32'h0145D7E1;
         5'd6:    a = 32'h00A2F61E;
         5'd7:    a = 32'h00517C55;
         5'd8:    a = 32'h0028BE53;
         5'd9:    a = 32'h00145F2F;
         5'd10:   a = 32'h000A2F98;
         5'd11:   a = 32'h000517CC;
         5'd12:   a = 32'h00028BE6;
         5'd13:   a = 32'h000145F3;
         5'd14:   a = 32'h0000A2FA;
         5'd15:   a = 32'h0000517D;
         5'd16:   a = 32'h000028BE;
         5'd17:   a = 32'h0000145F;
         5'd18:   a = 32'h00000A30;
         5'd19:   a = 32'h00000518;
         5'd20:   a = 32'h0000028C;
         5'd21:   a = 32'h00000146;
         5'd22:   a = 32'h000000A3;
         5'd23:   a = 32'h00000051;
         5'd24:   a = 32'h00000029;
         5'd25:   a = 32'h00000014;
         5'd26:   a = 32'h0000000A;
         5'd27:   a = 32'h00000005;
         5'd28:   a = 32'h00000003;
         5'd29:   a = 32'h00000001;
         default: a = 32'h00000000;
      endcase
      return a;
   endfunction

endpackage

// ----- sv/wvs_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wvs_front: input side of the wind vector statistics block
// Accepts sample items and holds them in a two-entry queue for the engine.
// ----------------------------------------------------------------------------
module wvs_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [31:0]         req_tdata,
   input  logic                pop,
   output logic                q_valid,
   output wvs_pkg::item_type   q_item
);

   wvs_pkg::item_type entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        fill_ff, fill_in;
   logic              push;
   logic              take;

   assign req_tready = (fill_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (fill_ff != 2'd0);
   assign take       = pop && q_valid;
   assign q_item     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= req_tdata;
      end
   end

endmodule

// ----- sv/wvs_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wvs_back: statistics engine of the wind vector statistics block
// Rotates each accepted sample into east and north parts, updates the sums, then
// vectors the sums into magnitude and angle and divides by the count.
// ----------------------------------------------------------------------------
module wvs_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  wvs_pkg::item_type   q_item,
   output logic                pop,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [63:0]         rsp_tdata,
   output logic [1:0]          rsp_tuser
);

   typedef enum logic [3:0] {
      S_IDLE, S_MUL, S_ROT, S_UPD, S_VSET, S_VEC, S_MAGH, S_MAGL,
      S_DIVSET, S_DIV, S_DONE
   } state_type;

   localparam int SW = wvs_pkg::SPEED_WIDTH;
   localparam int CW = wvs_pkg::COUNT_WIDTH;
   localparam int MW = wvs_pkg::SUM_WIDTH;
   localparam int WW = wvs_pkg::WORK_WIDTH;

   state_type                   state_ff;
   logic [SW-1:0]               speed_ff;
   logic [wvs_pkg::ANGLE_WIDTH-1:0] angle_ff;
   logic                        rejected_ff;
   logic signed [WW-1:0]        x_ff, y_ff;
   logic [31:0]                 z_ff;
   logic [wvs_pkg::STEP_BITS-1:0] step_ff;
   logic signed [MW-1:0]        east_ff, north_ff;
   logic [SW-1:0]               lowest_ff, highest_ff;
   logic [CW-1:0]               count_ff;
   logic [WW-1:0]               mag_ff;
   logic [CW-1:0]               rem_ff;
   logic [15:0]                 num_ff;
   logic [SW-1:0]               avg_ff;
   logic                        dir_zero_ff;
   logic                        out_valid_ff;
   logic [63:0]                 out_data_ff;
   logic [1:0]                  out_user_ff;

   logic [46:0]                 prod;
   logic [31:0]                 x_start;
   logic [31:0]                 turn;
   logic signed [WW-1:0]        dx, dy;
   logic [31:0]                 arc;
   logic signed [WW-1:0]        ex_abs, ny_abs;
   logic [WW-1:0]               ex_rnd, ny_rnd;
   logic [SW-1:0]               ex_mag, ny_mag;
   logic signed [MW-1:0]        ex_comp, ny_comp;
   logic signed [MW-1:0]        east_new, north_new;
   logic [MW-1:0]               east_abs, north_abs;
   logic [63:0]                 hi_prod;
   logic [60:0]                 lo_prod;
   logic [64:0]                 div_sum;
   logic [38:0]                 div_num;
   logic [CW:0]                 rem_try;
   logic [31:0]                 dir_sum;
   logic                        out_free;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign pop        = (state_ff == S_IDLE) && q_valid;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

   always_comb begin
      prod    = {1'b0, {14'd0, speed_ff} * {16'd0, wvs_pkg::GAIN_Q30}}
                + 47'd8192;
      x_start = prod[45:14];
      turn    = {angle_ff, 16'd0};
      dx      = y_ff >>> step_ff;
      dy      = x_ff >>> step_ff;
      arc     = wvs_pkg::arc_angle(step_ff);

      ex_abs  = x_ff[WW-1] ? -x_ff : x_ff;
      ny_abs  = y_ff[WW-1] ? -y_ff : y_ff;
      ex_rnd  = (ex_abs + 64'sd32768) >>> wvs_pkg::ROT_FRAC;
      ny_rnd  = (ny_abs + 64'sd32768) >>> wvs_pkg::ROT_FRAC;
      ex_mag  = (ex_rnd > 64'd65535) ? {SW{1'b1}} : ex_rnd[SW-1:0];
      ny_mag  = (ny_rnd > 64'd65535) ? {SW{1'b1}} : ny_rnd[SW-1:0];
      ex_comp = x_ff[WW-1] ? -$signed({{(MW-SW){1'b0}}, ex_mag})
                           :  $signed({{(MW-SW){1'b0}}, ex_mag});
      ny_comp = y_ff[WW-1] ? -$signed({{(MW-SW){1'b0}}, ny_mag})
                           :  $signed({{(MW-SW){1'b0}}, ny_mag});
      east_new  = east_ff + ex_comp;
      north_new = north_ff + ny_comp;

      east_abs  = east_ff[MW-1] ? -east_ff : east_ff;
      north_abs = north_ff[MW-1] ? -north_ff : north_ff;

      hi_prod = {32'd0, x_ff[61:30]} * {34'd0, wvs_pkg::GAIN_Q30};
      lo_prod = {31'd0, x_ff[29:0]} * {31'd0, wvs_pkg::GAIN_Q30} + 61'h2000_0000;

      div_sum = {1'b0, mag_ff} + {24'd0, count_ff, 25'd0};
      div_num = div_sum[64:26];

      rem_try = {rem_ff, num_ff[15]};
      dir_sum = z_ff + 32'h0000_8000;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         east_ff      <= '0;
         north_ff     <= '0;
         lowest_ff    <= {SW{1'b1}};
         highest_ff   <= '0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_valid_ff && rsp_tready && state_ff != S_DONE) begin
            out_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  speed_ff    <= q_item.wind_speed;
                  angle_ff    <= q_item.wind_direction;
                  rejected_ff <= (count_ff == {CW{1'b1}});
                  state_ff    <= (count_ff == {CW{1'b1}}) ? S_VSET : S_MUL;
               end
            end
            S_MUL: begin
               if (turn[31] ^ turn[30]) begin
                  x_ff <= -$signed({32'd0, x_start});
                  z_ff <= turn ^ 32'h8000_0000;
               end else begin
                  x_ff <= $signed({32'd0, x_start});
                  z_ff <= turn;
               end
               y_ff     <= '0;
               step_ff  <= '0;
               state_ff <= S_ROT;
            end
            S_ROT: begin
               if (!z_ff[31]) begin
                  x_ff <= x_ff - dx;
                  y_ff <= y_ff + dy;
                  z_ff <= z_ff - arc;
               end else begin
                  x_ff <= x_ff + dx;
                  y_ff <= y_ff - dy;
                  z_ff <= z_ff + arc;
               end
               step_ff <= step_ff + 1'b1;
               if (step_ff == wvs_pkg::STEP_BITS'(wvs_pkg::STEPS - 1)) begin
                  state_ff <= S_UPD;
               end
            end
            S_UPD: begin
               east_ff  <= east_new;
               north_ff <= north_new;
               count_ff <= count_ff + 1'b1;
               if (speed_ff < lowest_ff) begin
                  lowest_ff <= speed_ff;
               end
               if (speed_ff > highest_ff) begin
                  highest_ff <= speed_ff;
               end
               state_ff <= S_VSET;
            end
            S_VSET: begin
               dir_zero_ff <= (count_ff == '0 || (east_ff == '0 && north_ff == '0));
               step_ff     <= '0;
               priority if (count_ff == '0 || (east_ff == '0 && north_ff == '0)) begin
                  avg_ff      <= '0;
                  state_ff    <= S_DONE;
               end else if (north_ff == '0) begin
                  mag_ff   <= {4'd0, east_abs, 26'd0};
                  z_ff     <= east_ff[MW-1] ? 32'h8000_0000 : 32'h0000_0000;
                  state_ff <= S_DIVSET;
               end else if (east_ff == '0) begin
                  mag_ff   <= {4'd0, north_abs, 26'd0};
                  z_ff     <= north_ff[MW-1] ? 32'hC000_0000 : 32'h4000_0000;
                  state_ff <= S_DIVSET;
               end else begin
                  if (east_ff[MW-1]) begin
                     x_ff <= -$signed({{(WW-MW-26){east_ff[MW-1]}}, east_ff, 26'd0});
                     y_ff <= -$signed({{(WW-MW-26){north_ff[MW-1]}}, north_ff, 26'd0});
                     z_ff <= 32'h8000_0000;
                  end else begin
                     x_ff <= $signed({{(WW-MW-26){east_ff[MW-1]}}, east_ff, 26'd0});
                     y_ff <= $signed({{(WW-MW-26){north_ff[MW-1]}}, north_ff, 26'd0});
                     z_ff <= 32'h0000_0000;
                  end
                  state_ff <= S_VEC;
               end
            end
            S_VEC: begin
               if (!y_ff[WW-1]) begin
                  x_ff <= x_ff + dx;
                  y_ff <= y_ff - dy;
                  z_ff <= z_ff + arc;
               end else begin
                  x_ff <= x_ff - dx;
                  y_ff <= y_ff + dy;
                  z_ff <= z_ff - arc;
               end
               step_ff <= step_ff + 1'b1;
               if (step_ff == wvs_pkg::STEP_BITS'(wvs_pkg::STEPS - 1)) begin
                  state_ff <= S_MAGH;
               end
            end
            S_MAGH: begin
               mag_ff   <= hi_prod;
               state_ff <= S_MAGL;
            end
            S_MAGL: begin
               mag_ff   <= mag_ff + {33'd0, lo_prod[60:30]};
               state_ff <= S_DIVSET;
            end
            S_DIVSET: begin
               step_ff <= '0;
               if (div_num >= {7'd0, count_ff, 16'd0}) begin
                  avg_ff   <= {SW{1'b1}};
                  state_ff <= S_DONE;
               end else begin
                  rem_ff   <= div_num[31:16];
                  num_ff   <= div_num[15:0];
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               if (rem_try >= {1'b0, count_ff}) begin
                  rem_ff <= CW'(rem_try - {1'b0, count_ff});
                  avg_ff <= {avg_ff[SW-2:0], 1'b1};
               end else begin
                  rem_ff <= rem_try[CW-1:0];
                  avg_ff <= {avg_ff[SW-2:0], 1'b0};
               end
               num_ff  <= {num_ff[14:0], 1'b0};
               step_ff <= step_ff + 1'b1;
               if (step_ff == 5'd15) begin
                  state_ff <= S_DONE;
               end
            end
            S_DONE: begin
               if (out_free) begin
                  out_valid_ff <= 1'b1;
                  out_data_ff  <= {dir_zero_ff ? 16'd0 : dir_sum[31:16], avg_ff,
                                   highest_ff, lowest_ff};
                  out_user_ff  <= {rejected_ff, count_ff != '0};
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ----- sv/wind_vector_stats.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wind_vector_stats: running vector-averaged wind speed and direction
// Keeps minimum, maximum, count and east/north sums of wind samples and
// reports average speed and direction of the summed vector for every item.
// ----------------------------------------------------------------------------
// Channel   Direction  Payload
// req_*     in         tdata[15:0] wind_speed, tdata[31:16] wind_direction
// rsp_*     out        tdata: min, max, average speed, average direction;
//                      tuser[0] has_samples, tuser[1] sample_rejected
//
// An item passes the engine as pop, multiply, 30 rotation steps, update,
// vectoring setup, 30 vectoring steps, 2 gain multiplies, divide setup,
// 16 divide steps and finish, on a shared CORDIC datapath and serial divider;
// axis or zero sums, rejected samples and a saturated average skip part.
// Reset is synchronous and clears the statistics. A two-entry queue takes
// items while the engine works; a held result stalls only the next finish.
// ----------------------------------------------------------------------------
module wind_vector_stats (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // wind_speed, wind_direction
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // min, max, average_speed, average_direction
   output logic [1:0]  rsp_tuser    // has_samples, sample_rejected
);

   logic              pop;
   logic              q_valid;
   wvs_pkg::item_type q_item;

   wvs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .pop        (pop),
      .q_valid    (q_valid),
      .q_item     (q_item)
   );

   wvs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
